// ===== hw/rtl/pidl_pkg.sv =====
// Shared types and constants for the positional insert/delete list.
// Used by pidl_cell and positional_insert_delete_list_core; no dependencies.
package pidl_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int FUNC_W = 3;
  localparam int POS_W  = 5;
  localparam int OCNT_W = 5;
  localparam int STAT_W = 2;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT      = 3'd0,
    FUNC_APPEND      = 3'd1,
    FUNC_REMOVE      = 3'd2,
    FUNC_REMOVE_LAST = 3'd3,
    FUNC_DUMP        = 3'd4
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_ROT  = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e             op;
    logic [CNT_W-1:0]     pos;
    logic [IDX_W-1:0]     last_idx;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/pidl_cell.sv =====
// One storage cell of the list chain: holds a single entry and takes its next
// value from itself, a neighbour, the head of the chain or the new word.
// Depends on pidl_pkg.
module pidl_cell import pidl_pkg::*; (
  input  logic                     clk_i,
  input  cell_cmd_t                cmd_i,
  input  logic [IDX_W-1:0]         idx_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic signed [DATA_W-1:0] left_i,
  input  logic signed [DATA_W-1:0] right_i,
  input  logic signed [DATA_W-1:0] head_i,
  output logic signed [DATA_W-1:0] entry_o
);

  logic signed [DATA_W-1:0] entry_q, entry_d;
  logic [CNT_W-1:0]         idx_ext;

  assign idx_ext = CNT_W'(idx_i);

  always_comb begin
    entry_d = entry_q;
    case (cmd_i.op)
      CELL_INS: begin
        if (idx_ext > cmd_i.pos) begin
          entry_d = left_i;
        end else if (idx_ext == cmd_i.pos) begin
          entry_d = value_i;
        end
      end
      CELL_DEL: begin
        if (idx_ext >= cmd_i.pos) begin
          entry_d = right_i;
        end
      end
      CELL_ROT: begin
        if (idx_i < cmd_i.last_idx) begin
          entry_d = right_i;
        end else if (idx_i == cmd_i.last_idx) begin
          entry_d = head_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== hw/rtl/positional_insert_delete_list_core.sv =====
// Top level of the positional insert/delete list: control, result register
// and the row of pidl_cell storage cells. Depends on pidl_pkg and pidl_cell.
//
// The list is held in a row of DEPTH cells that all shift in the same cycle, so
// every insert, append or remove updates the whole row at once and its single
// result is registered at the output. A dump rotates the occupied cells by one
// place and streams the head entry, one result per cycle while the output is
// not stalled and one per entry; no new request is taken until it has finished.
// A request is taken whenever the output register is empty or being drained.
module positional_insert_delete_list_core import pidl_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [FUNC_W-1:0]        func_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [STAT_W-1:0]        status_o,
  output logic signed [DATA_W-1:0] data_o,
  output logic [OCNT_W-1:0]        entry_count_o,
  output logic                     last_o
);

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_e;

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         fill_q, fill_d;
  logic [IDX_W-1:0]         dump_idx_q, dump_idx_d;
  logic                     out_valid_q, out_valid_d;
  status_e                  status_q, status_d;
  logic signed [DATA_W-1:0] data_q, data_d;
  logic [OCNT_W-1:0]        count_q, count_d;
  logic                     last_q, last_d;

  cell_cmd_t                cmd;
  logic signed [DATA_W-1:0] entry_w [DEPTH];
  logic                     out_free, in_acc, emit;
  logic [CMP_W-1:0]         pos_ext, fill_ext;
  logic [IDX_W-1:0]         last_idx;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign pos_ext    = CMP_W'(position_i);
  assign fill_ext   = CMP_W'(fill_q);
  assign last_idx   = IDX_W'(fill_q - CNT_W'(1));

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    dump_idx_d   = dump_idx_q;
    status_d     = status_q;
    data_d       = data_q;
    count_d      = count_q;
    last_d       = last_q;
    emit         = 1'b0;
    cmd.op       = CELL_HOLD;
    cmd.pos      = CNT_W'(pos_ext);
    cmd.last_idx = last_idx;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          emit     = 1'b1;
          status_d = ST_OK;
          data_d   = '0;
          last_d   = 1'b1;
          case (func_i)
            FUNC_INSERT: begin
              if (pos_ext > fill_ext) begin
                status_d = ST_BOUNDS;
              end else if (fill_ext == CMP_W'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                cmd.op = CELL_INS;
                fill_d = fill_q + CNT_W'(1);
              end
            end
            FUNC_APPEND: begin
              if (fill_ext == CMP_W'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                cmd.op  = CELL_INS;
                cmd.pos = fill_q;
                fill_d  = fill_q + CNT_W'(1);
              end
            end
            FUNC_REMOVE: begin
              if (fill_q == '0) begin
                status_d = ST_EMPTY;
              end else if (pos_ext >= fill_ext) begin
                status_d = ST_BOUNDS;
              end else begin
                cmd.op = CELL_DEL;
                fill_d = fill_q - CNT_W'(1);
              end
            end
            FUNC_REMOVE_LAST: begin
              if (fill_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                fill_d = fill_q - CNT_W'(1);
              end
            end
            FUNC_DUMP: begin
              if (fill_q == '0) begin
                status_d = ST_EMPTY;
              end else begin
                emit       = 1'b0;
                dump_idx_d = '0;
                state_d    = S_DUMP;
              end
            end
            default: status_d = ST_OK;
          endcase
          count_d = OCNT_W'(fill_d);
        end
      end
      S_DUMP: begin
        if (out_free) begin
          emit       = 1'b1;
          cmd.op     = CELL_ROT;
          status_d   = ST_OK;
          data_d     = entry_w[0];
          count_d    = OCNT_W'(fill_q);
          last_d     = (dump_idx_q == last_idx);
          dump_idx_d = dump_idx_q + IDX_W'(1);
          if (dump_idx_q == last_idx) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      dump_idx_q  <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      data_q      <= '0;
      count_q     <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      dump_idx_q  <= dump_idx_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      data_q      <= data_d;
      count_q     <= count_d;
      last_q      <= last_d;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_w, right_w;

    if (g == 0) begin : g_first
      assign left_w = value_i;
    end else begin : g_mid_l
      assign left_w = entry_w[g-1];
    end

    if (g == DEPTH - 1) begin : g_end
      assign right_w = entry_w[g];
    end else begin : g_mid_r
      assign right_w = entry_w[g+1];
    end

    pidl_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .idx_i   (IDX_W'(g)),
      .value_i (value_i),
      .left_i  (left_w),
      .right_i (right_w),
      .head_i  (entry_w[0]),
      .entry_o (entry_w[g])
    );
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign data_o        = data_q;
  assign entry_count_o = count_q;
  assign last_o        = last_q;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking bench for positional_insert_delete_list_core. It sends directed and random
// list requests, mirrors the list in a queue and checks every result in order.
// Depends on pidl_pkg and the list core RTL only.
module tb;
  import pidl_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE_5 = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;
  localparam logic [DATA_W-1:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] WORD_ONES = 32'hffff_ffff;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SHOWN_ERRORS = 10;
  localparam int RANDOM_REQUESTS = 395;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] data;
    logic [OCNT_W-1:0] count;
    logic              last;
  } result_t;

  typedef enum int {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY} stall_style_e;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [FUNC_W-1:0]        req_func = '0;
  logic [POS_W-1:0]         req_position = '0;
  logic signed [DATA_W-1:0] req_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STAT_W-1:0]        res_status;
  logic signed [DATA_W-1:0] res_data;
  logic [OCNT_W-1:0]        res_count;
  logic                     res_last;

  positional_insert_delete_list_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .func_i        (req_func),
    .position_i    (req_position),
    .value_i       (req_value),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (res_status),
    .data_o        (res_data),
    .entry_count_o (res_count),
    .last_o        (res_last)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [DATA_W-1:0] list_mirror[$];
  result_t           expected_results[$];
  request_t          request_queue[$];
  request_t          held_req;
  result_t           observed;
  result_t           wanted;
  int                gen_fill = 0;
  int                error_count = 0;
  int                cycle_count = 0;
  int                burst_left = 1;
  int                gap_left = 0;
  int                stall_span = 0;
  stall_style_e      stall_style = STALL_NONE;

  task automatic post_result(input status_e st, input logic [DATA_W-1:0] word,
                             input logic fin);
    expected_results.push_back('{status: st, data: word,
                                 count: OCNT_W'(list_mirror.size()), last: fin});
  endtask

  task automatic predict_list_op(input request_t req);
    int held;
    int idx;
    held = list_mirror.size();
    idx = int'(req.position);
    case (req.func)
      FUNC_INSERT: begin
        if (idx > held) begin
          post_result(ST_BOUNDS, '0, 1'b1);
        end else if (held >= DEPTH) begin
          post_result(ST_FULL, '0, 1'b1);
        end else begin
          list_mirror.insert(idx, req.value);
          post_result(ST_OK, '0, 1'b1);
        end
      end
      FUNC_APPEND: begin
        if (held >= DEPTH) begin
          post_result(ST_FULL, '0, 1'b1);
        end else begin
          list_mirror.push_back(req.value);
          post_result(ST_OK, '0, 1'b1);
        end
      end
      FUNC_REMOVE: begin
        if (held == 0) begin
          post_result(ST_EMPTY, '0, 1'b1);
        end else if (idx >= held) begin
          post_result(ST_BOUNDS, '0, 1'b1);
        end else begin
          list_mirror.delete(idx);
          post_result(ST_OK, '0, 1'b1);
        end
      end
      FUNC_REMOVE_LAST: begin
        if (held == 0) begin
          post_result(ST_EMPTY, '0, 1'b1);
        end else begin
          void'(list_mirror.pop_back());
          post_result(ST_OK, '0, 1'b1);
        end
      end
      FUNC_DUMP: begin
        if (held == 0) begin
          post_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int k = 0; k < held; k++) begin
            post_result(ST_OK, list_mirror[k], k == held - 1);
          end
        end
      end
      default: begin
        post_result(ST_OK, '0, 1'b1);
      end
    endcase
  endtask

  // The fill level is tracked while the stimulus is built so that most positions are legal.
  task automatic queue_request(input logic [FUNC_W-1:0] f, input int p,
                               input logic [DATA_W-1:0] v);
    request_queue.push_back('{func: f, position: POS_W'(p), value: v});
    case (f)
      FUNC_INSERT: if (p <= gen_fill && gen_fill < DEPTH) gen_fill++;
      FUNC_APPEND: if (gen_fill < DEPTH) gen_fill++;
      FUNC_REMOVE: if (p < gen_fill) gen_fill--;
      FUNC_REMOVE_LAST: if (gen_fill > 0) gen_fill--;
      default: ;
    endcase
  endtask

  function automatic logic [DATA_W-1:0] pick_word();
    if ($urandom_range(0, 9) != 0) begin
      return $urandom;
    end
    case ($urandom_range(0, 3))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return WORD_ONES;
      default: return '0;
    endcase
  endfunction

  function automatic int pick_position(input int span);
    if (span >= 0 && $urandom_range(0, 99) < 85) begin
      return $urandom_range(0, span);
    end
    return $urandom_range(0, 31);
  endfunction

  task automatic queue_grow_op();
    if ($urandom_range(0, 1) == 1) begin
      queue_request(FUNC_INSERT, pick_position(gen_fill), pick_word());
    end else begin
      queue_request(FUNC_APPEND, $urandom_range(0, 31), pick_word());
    end
  endtask

  task automatic queue_shrink_op();
    if ($urandom_range(0, 1) == 1) begin
      queue_request(FUNC_REMOVE, pick_position(gen_fill - 1), pick_word());
    end else begin
      queue_request(FUNC_REMOVE_LAST, $urandom_range(0, 31), pick_word());
    end
  endtask

  task automatic build_stimulus();
    int made;
    int seg;
    int roll;
    bit grow;
    queue_request(FUNC_DUMP, 0, '0);
    queue_request(FUNC_REMOVE, 0, '0);
    queue_request(FUNC_REMOVE_LAST, 0, '0);
    queue_request(FUNC_INSERT, 1, WORD_ONES);
    queue_request(FUNC_INSERT, 0, WORD_MAX);
    queue_request(FUNC_APPEND, 0, WORD_MIN);
    queue_request(FUNC_INSERT, 1, WORD_ONES);
    queue_request(FUNC_INSERT, 3, '0);
    queue_request(FUNC_INSERT, 31, 32'h1234_5678);
    queue_request(FUNC_INSERT, 5, 32'h0000_0001);
    queue_request(FUNC_DUMP, 0, '0);
    queue_request(FUNC_REMOVE, 4, '0);
    queue_request(FUNC_REMOVE, 31, '0);
    queue_request(FUNC_REMOVE, 1, '0);
    queue_request(FUNC_REMOVE, 0, '0);
    queue_request(FUNC_SPARE_5, 31, WORD_ONES);
    queue_request(FUNC_SPARE_6, 16, WORD_MIN);
    queue_request(FUNC_SPARE_7, 0, WORD_MAX);
    queue_request(FUNC_REMOVE_LAST, 0, '0);
    queue_request(FUNC_DUMP, 0, '0);
    queue_request(FUNC_REMOVE_LAST, 0, '0);
    queue_request(FUNC_DUMP, 0, '0);

    made = 0;
    while (gen_fill < DEPTH) begin
      queue_grow_op();
      made++;
    end
    queue_request(FUNC_INSERT, $urandom_range(0, DEPTH), pick_word());
    queue_request(FUNC_APPEND, 0, pick_word());
    queue_request(FUNC_DUMP, 0, '0);
    made += 3;
    while (gen_fill > 0) begin
      queue_shrink_op();
      made++;
    end
    queue_request(FUNC_REMOVE_LAST, 0, '0);
    made++;

    while (made < RANDOM_REQUESTS) begin
      grow = 1'($urandom_range(0, 1));
      seg = $urandom_range(8, 40);
      repeat (seg) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          queue_request(3'($urandom_range(FUNC_SPARE_5, FUNC_SPARE_7)),
                        $urandom_range(0, 31), pick_word());
        end else if (roll < 14) begin
          queue_request(FUNC_DUMP, $urandom_range(0, 31), pick_word());
        end else if ((roll < 71) == grow) begin
          queue_grow_op();
        end else begin
          queue_shrink_op();
        end
        made++;
      end
    end
  endtask

  task automatic flag_mismatch(input string what, input result_t exp_r, input result_t got_r);
    error_count++;
    if (error_count <= SHOWN_ERRORS) begin
      $display("%s: expected status %0d data %h count %0d last %0b,",
               what, exp_r.status, exp_r.data, exp_r.count, exp_r.last,
               " got status %0d data %h count %0d last %0b",
               got_r.status, got_r.data, got_r.count, got_r.last);
    end
  endtask

  always @(posedge clk_i) begin
    if (in_valid && !in_stall) begin
      predict_list_op(held_req);
    end
    if (!in_valid || !in_stall) begin
      if (rst_ni && gap_left == 0 && request_queue.size() > 0) begin
        held_req = request_queue.pop_front();
        req_func <= held_req.func;
        req_position <= held_req.position;
        req_value <= held_req.value;
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_span == 0) begin
      stall_style = stall_style_e'($urandom_range(0, 3));
      stall_span = $urandom_range(16, 80);
    end else begin
      stall_span--;
    end
    case (stall_style)
      STALL_NONE: out_stall <= 1'b0;
      STALL_COIN: out_stall <= ($urandom_range(0, 1) == 1);
      STALL_PERIODIC: out_stall <= (stall_span % 3 == 0);
      default: out_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      observed = '{status: res_status, data: res_data, count: res_count, last: res_last};
      if (expected_results.size() == 0) begin
        flag_mismatch("Unexpected result", '0, observed);
      end else begin
        wanted = expected_results.pop_front();
        if (observed !== wanted) begin
          flag_mismatch("Result mismatch", wanted, observed);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    do begin
      @(negedge clk_i);
    end while (request_queue.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (24) @(negedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
